@@ design/tea_pkg.sv @@
package tea_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [WordW-1:0] word_t;

  localparam word_t Delta = 32'h9E37_79B9;

  typedef enum logic [CfgIdxW-1:0] {
    KEY_W0 = 2'd0,
    KEY_W1 = 2'd1,
    KEY_W2 = 2'd2,
    KEY_W3 = 2'd3
  } cfg_idx_e;

  localparam int unsigned NumKeys = 4;

  // TEA mixing function; addition binds tighter than XOR
  function automatic word_t mix(word_t x, word_t s, word_t ka, word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (x << 4) + ka;
    b = x + s;
    c = (x >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

@@ design/tea_if.sv @@
interface tea_in_if;
  import tea_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  word_t block_left;
  word_t block_right;

  modport source (output valid, output cmd, output block_left, output block_right,
                  input ready);
  modport sink   (input valid, input cmd, input block_left, input block_right,
                  output ready);
endinterface

interface tea_out_if;
  import tea_pkg::*;

  logic  valid;
  logic  ready;
  word_t out_left;
  word_t out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

@@ design/tea_block_cipher.sv @@
// Channel   Dir  Fields                        Transfer
// in_i      in   cmd, block_left, block_right  valid & ready
// out_o     out  out_left, out_right           valid & ready
// cfg       in   cfg_idx_i, cfg_wdata_i        cfg_we_i
//
// One half-round per stage, 2*ROUNDS stages; the last stage is the output register.
// Blocks pass through the stage registers in order; one block accepted per cycle unless out_o stalls.
// A stall at out_o freezes the whole pipeline; bubbles are not squeezed out.
// Reset clears the stage valid bits and the key words.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tea_in_if.sink                      in_i,
  tea_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [tea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tea_pkg::WordW-1:0]   cfg_wdata_i
);
  import tea_pkg::*;

  localparam int unsigned Stages = 2 * ROUNDS;

  word_t key_q [NumKeys];

  logic  vld_q [Stages];
  logic  dec_q [Stages];
  word_t l_q   [Stages];
  word_t r_q   [Stages];

  logic  advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeys; k++) key_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        KEY_W0: key_q[0] <= cfg_wdata_i;
        KEY_W1: key_q[1] <= cfg_wdata_i;
        KEY_W2: key_q[2] <= cfg_wdata_i;
        KEY_W3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign advance = !vld_q[Stages-1] || out_o.ready;
  assign in_i.ready = advance;

  for (genvar j = 0; j < Stages; j++) begin : g_stg
    localparam int unsigned Rnd = j / 2;
    localparam logic [63:0] SumEWide = 64'(Delta) * 64'(Rnd + 1);
    localparam logic [63:0] SumDWide = 64'(Delta) * 64'(ROUNDS - Rnd);
    localparam word_t SumE = SumEWide[WordW-1:0];
    localparam word_t SumD = SumDWide[WordW-1:0];

    logic  vld_in;
    logic  dec_in;
    word_t l_in;
    word_t r_in;
    word_t l_d;
    word_t r_d;

    if (j == 0) begin : g_src_in
      assign vld_in = in_i.valid;
      assign dec_in = in_i.cmd;
      assign l_in   = in_i.block_left;
      assign r_in   = in_i.block_right;
    end else begin : g_src_stg
      assign vld_in = vld_q[j-1];
      assign dec_in = dec_q[j-1];
      assign l_in   = l_q[j-1];
      assign r_in   = r_q[j-1];
    end

    if (j % 2 == 0) begin : g_half_a
      always_comb begin
        l_d = l_in;
        r_d = r_in;
        if (dec_in) begin
          r_d = r_in - mix(l_in, SumD, key_q[2], key_q[3]);
        end else begin
          l_d = l_in + mix(r_in, SumE, key_q[0], key_q[1]);
        end
      end
    end else begin : g_half_b
      always_comb begin
        l_d = l_in;
        r_d = r_in;
        if (dec_in) begin
          l_d = l_in - mix(r_in, SumD, key_q[0], key_q[1]);
        end else begin
          r_d = r_in + mix(l_in, SumE, key_q[2], key_q[3]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (advance) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance && vld_in) begin
        dec_q[j] <= dec_in;
        l_q[j]   <= l_d;
        r_q[j]   <= r_d;
      end
    end
  end

  assign out_o.valid     = vld_q[Stages-1];
  assign out_o.out_left  = l_q[Stages-1];
  assign out_o.out_right = r_q[Stages-1];

endmodule

@@ verif/tea_tb_pkg.sv @@
package tea_tb_pkg;

  typedef enum logic {
    TEA_ENCRYPT = 1'b0,
    TEA_DECRYPT = 1'b1
  } tea_op_e;

  typedef struct packed {
    tea_pkg::word_t left;
    tea_pkg::word_t right;
  } tea_halves_t;

endpackage

@@ verif/tea_checker.sv @@
module tea_checker #(
  parameter int unsigned Rounds = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tea_in_if                           in_mon,
  tea_out_if                          out_mon,
  input  logic                        cfg_we_i,
  input  logic [tea_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  tea_pkg::word_t              cfg_wdata_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tea_pkg::*;
  import tea_tb_pkg::*;

  word_t       key_q [NumKeys];
  tea_halves_t expected_q[$];
  tea_halves_t got;
  tea_halves_t want;

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic word_t round_f(word_t x, word_t s, word_t ka, word_t kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  function automatic tea_halves_t tea_transform(tea_op_e op, word_t l, word_t r);
    word_t       sum;
    tea_halves_t res;
    if (op == TEA_ENCRYPT) begin
      sum = '0;
      for (int n = 0; n < Rounds; n++) begin
        sum += Delta;
        l += round_f(r, sum, key_q[KEY_W0], key_q[KEY_W1]);
        r += round_f(l, sum, key_q[KEY_W2], key_q[KEY_W3]);
      end
    end else begin
      sum = word_t'(Delta * Rounds);
      for (int n = 0; n < Rounds; n++) begin
        r -= round_f(l, sum, key_q[KEY_W2], key_q[KEY_W3]);
        l -= round_f(r, sum, key_q[KEY_W0], key_q[KEY_W1]);
        sum -= Delta;
      end
    end
    res.left  = l;
    res.right = r;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (key_q[i]) key_q[i] = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.left  = out_mon.out_left;
        got.right = out_mon.out_right;
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %h %h", got.left, got.right));
        end else begin
          want = expected_q.pop_front();
          if (got.left !== want.left) begin
            report($sformatf("out_left got %h expected %h", got.left, want.left));
          end
          if (got.right !== want.right) begin
            report($sformatf("out_right got %h expected %h", got.right, want.right));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(tea_transform(tea_op_e'(in_mon.cmd), in_mon.block_left,
                                           in_mon.block_right));
      end
      if (cfg_we_i) begin
        key_q[cfg_idx_i] = cfg_wdata_i;
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tea_pkg::*;
  import tea_tb_pkg::*;

  localparam int unsigned Rounds     = 32;
  localparam int unsigned MaxGap     = 12;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  word_t              cfg_wdata;
  logic               calm;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        idle_cycles = 0;

  tea_in_if  in_ch ();
  tea_out_if out_ch ();

  tea_block_cipher #(
    .ROUNDS(Rounds)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  tea_checker #(
    .Rounds(Rounds)
  ) chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WordW - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WordW - 1));
      default: return $urandom();
    endcase
  endfunction

  // Returns at the edge of the transfer; valid stays high
  task automatic send_block(tea_op_e op, word_t l, word_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= op;
    in_ch.block_left  <= l;
    in_ch.block_right <= r;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    word_t    words[NumKeys];
    cfg_idx_e idx;
    words = '{k0, k1, k2, k3};
    drain();
    idx = KEY_W0;
    for (int i = 0; i < NumKeys; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= words[i];
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_extremes();
    tea_op_e op;
    op = TEA_ENCRYPT;
    for (int i = 0; i < 2; i++) begin
      send_block(op, '0, '0);
      send_block(op, '1, '1);
      send_block(op, '0, '1);
      op = TEA_DECRYPT;
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = KEY_W0;
    cfg_wdata         = '0;
    calm              = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = TEA_ENCRYPT;
    in_ch.block_left  = '0;
    in_ch.block_right = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // key still at its reset value
    send_extremes();
    load_key('1, '1, '1, '1);
    send_extremes();
    load_key(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
    send_extremes();
    send_block(TEA_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    send_block(TEA_DECRYPT, 32'h0000_0001, 32'h8000_0000);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: load_key('0, '0, '0, '0);
        1: load_key('1, '1, '1, '1);
        2: load_key(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
        default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        if (i == PhaseItems / 2) drain();
        send_block(tea_op_e'($urandom_range(0, 1)), rand_word(), rand_word());
      end
    end

    drain();
    calm = 1'b0;
    repeat (2 * Rounds + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // no transfer on either side for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
